// ===== hw/rtl/fdes_pkg.sv =====
// shared types, constants and name helpers for the directory entry scan
package fdes_pkg;

    localparam int CMD_DEPTH_DEF = 2;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_INDEX  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRIES_LIMIT = 1'b1;

    localparam logic [7:0] MARK_DELETED = 8'hE5;
    localparam logic [7:0] MARK_END     = 8'h00;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_DOT       = 8'h2E;
    localparam int ATTR_VOLUME_BIT = 3;
    localparam int ATTR_DIR_BIT    = 4;

    typedef struct packed {
        logic        start_scan;
        logic [63:0] base_name;
        logic [23:0] extension;
        logic [7:0]  attributes;
    } entry_t;

    typedef struct packed {
        logic       status;
        logic [7:0] character;
        logic       last;
    } result_t;

    // work handed from the classifier to the name expander
    typedef struct packed {
        logic        missing;
        logic [63:0] base_name;
        logic [23:0] extension;
        logic [3:0]  base_len;
        logic        has_dot;
        logic [1:0]  ext_len;
    } cmd_t;

    function automatic logic [3:0] base_length(input logic [63:0] b);
        logic [3:0] n;
        logic       stop;
        n    = '0;
        stop = 1'b0;
        for (int i = 0; i < 8; i++)
        begin
            if (!stop)
            begin
                if (b[8*i +: 8] == CH_SPACE)
                    stop = 1'b1;
                else
                    n = n + 4'd1;
            end
        end
        return n;
    endfunction

    function automatic logic [1:0] ext_length(input logic [23:0] e);
        logic [1:0] n;
        logic       stop;
        n    = '0;
        stop = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            if (!stop)
            begin
                if (e[8*i +: 8] == CH_SPACE)
                    stop = 1'b1;
                else
                    n = n + 2'd1;
            end
        end
        return n;
    endfunction

endpackage

// ===== hw/rtl/fdes_front.sv =====
// front end: config registers, scan counters and per-entry classification
module fdes_front
    import fdes_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                 accept,
    input  entry_t               item,
    output logic                 cmd_push,
    output cmd_t                 cmd
);

    logic [15:0] target_reg;
    logic [15:0] limit_reg;
    logic [15:0] slots_reg;
    logic [15:0] slots_next;
    logic [15:0] skip_reg;
    logic [15:0] skip_next;
    logic        fin_reg;
    logic        fin_next;

    logic [15:0] slots_eff;
    logic [15:0] skip_eff;
    logic [15:0] slots_dec;
    logic        fin_eff;
    logic [7:0]  first;
    logic        is_volume;
    logic        is_deleted;
    logic        emit;
    logic        missing;

    assign first      = item.base_name[7:0];
    assign is_volume  = item.attributes[ATTR_VOLUME_BIT];
    assign is_deleted = (first == MARK_DELETED);
    assign slots_eff  = item.start_scan ? limit_reg  : slots_reg;
    assign skip_eff   = item.start_scan ? target_reg : skip_reg;
    assign fin_eff    = item.start_scan ? 1'b0       : fin_reg;
    assign slots_dec  = slots_eff - 16'd1;

    always_comb
    begin
        slots_next = slots_eff;
        skip_next  = skip_eff;
        fin_next   = fin_eff;
        emit       = 1'b0;
        missing    = 1'b0;
        priority if (item.start_scan && limit_reg == '0)
        begin
            emit     = 1'b1;
            missing  = 1'b1;
            fin_next = 1'b1;
        end
        else if (fin_eff)
        begin
            emit = 1'b0;
        end
        else if (first == MARK_END)
        begin
            emit     = 1'b1;
            missing  = 1'b1;
            fin_next = 1'b1;
        end
        else if (is_volume || is_deleted || skip_eff != '0)
        begin
            if (!is_volume && !is_deleted)
                skip_next = skip_eff - 16'd1;
            slots_next = slots_dec;
            if (slots_dec == '0)
            begin
                emit     = 1'b1;
                missing  = 1'b1;
                fin_next = 1'b1;
            end
        end
        else
        begin
            // this is the wanted entry
            emit     = 1'b1;
            fin_next = 1'b1;
        end
    end

    assign cmd_push      = accept && emit;
    assign cmd.missing   = missing;
    assign cmd.base_name = item.base_name;
    assign cmd.extension = item.extension;
    assign cmd.base_len  = base_length(item.base_name);
    assign cmd.has_dot   = !(item.attributes[ATTR_DIR_BIT] && item.extension[7:0] == CH_SPACE);
    assign cmd.ext_len   = ext_length(item.extension);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
            limit_reg  <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_TARGET_INDEX:  target_reg <= cfg_data;
                REG_ENTRIES_LIMIT: limit_reg  <= cfg_data;
                default:           target_reg <= target_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_reg <= '0;
            skip_reg  <= '0;
            fin_reg   <= 1'b1;
        end
        else if (accept)
        begin
            slots_reg <= slots_next;
            skip_reg  <= skip_next;
            fin_reg   <= fin_next;
        end
    end

endmodule

// ===== hw/rtl/fdes_queue.sv =====
// small command queue between the classifier and the name expander
module fdes_queue
    import fdes_pkg::*;
#(
    parameter int DEPTH = CMD_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t data_in,
    output logic full,
    input  logic pop,
    output cmd_t data_out,
    output logic empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_FULL);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign data_out = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= data_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule

// ===== hw/rtl/fdes_back.sv =====
// back end: expands a command into result items, one per cycle unless stalled
module fdes_back
    import fdes_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    q_empty,
    input  cmd_t    q_data,
    output logic    q_pop,
    input  logic    pop,
    output logic    empty,
    output result_t result
);

    logic       cur_valid_reg;
    cmd_t       cur_reg;
    logic [3:0] pos_reg;
    logic       out_valid_reg;
    result_t    out_reg;

    logic [3:0] n_raw;
    logic       blank;
    logic [3:0] n_last;
    logic       is_last;
    logic [3:0] ext_pos;
    logic       advance;
    logic       load;
    result_t    item_next;

    assign n_raw   = cur_reg.base_len + 4'(cur_reg.has_dot) + 4'(cur_reg.ext_len);
    assign blank   = (n_raw == '0);
    assign n_last  = (cur_reg.missing || blank) ? '0 : n_raw - 4'd1;
    assign is_last = (pos_reg == n_last);
    assign ext_pos = pos_reg - cur_reg.base_len - 4'(cur_reg.has_dot);

    always_comb
    begin
        item_next.status    = 1'b0;
        item_next.character = '0;
        item_next.last      = is_last;
        priority if (cur_reg.missing)
            item_next.status = 1'b1;
        else if (blank)
            item_next.character = '0;
        else if (pos_reg < cur_reg.base_len)
            item_next.character = cur_reg.base_name[8*pos_reg[2:0] +: 8];
        else if (cur_reg.has_dot && pos_reg == cur_reg.base_len)
            item_next.character = CH_DOT;
        else
            item_next.character = cur_reg.extension[8*ext_pos[1:0] +: 8];
    end

    assign advance = cur_valid_reg && (!out_valid_reg || pop);
    assign load    = !q_empty && (!cur_valid_reg || (advance && is_last));
    assign q_pop   = load;
    assign empty   = !out_valid_reg;
    assign result  = out_reg;

    always_ff @(posedge clk)
    begin
        if (load)
            cur_reg <= q_data;
        if (advance)
            out_reg <= item_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                cur_valid_reg <= 1'b1;
                pos_reg       <= '0;
            end
            else if (advance && is_last)
                cur_valid_reg <= 1'b0;
            else if (advance)
                pos_reg <= pos_reg + 4'd1;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

endmodule

// ===== hw/rtl/fat_directory_entry_scan.sv =====
// top level of the fat 8.3 directory entry scan
// path: an entry's first result item passes the command queue, cur_reg and out_reg
// throughput: one entry per cycle for skipped entries while the queue is not full;
// a match holds the name expander for up to 12 characters, one per cycle when popped
// reset: counters clear, the scan stays idle until an entry with start_scan set
module fat_directory_entry_scan
    import fdes_pkg::*;
#(
    parameter int CMD_DEPTH = CMD_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  push,
    output logic                  full,
    input  entry_t                entry,
    input  logic                  pop,
    output logic                  empty,
    output result_t               result
);

    logic accept;
    logic cmd_push;
    cmd_t cmd_in;
    cmd_t cmd_out;
    logic cmd_empty;
    logic cmd_pop;

    assign accept = push && !full;

    fdes_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .item      (entry),
        .cmd_push  (cmd_push),
        .cmd       (cmd_in)
    );

    fdes_queue #(
        .DEPTH (CMD_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (cmd_push),
        .data_in  (cmd_in),
        .full     (full),
        .pop      (cmd_pop),
        .data_out (cmd_out),
        .empty    (cmd_empty)
    );

    fdes_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (cmd_empty),
        .q_data  (cmd_out),
        .q_pop   (cmd_pop),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

endmodule

// ===== verif/fat_directory_entry_scan_tb.sv =====
// self-checking testbench for the directory entry scan: directed and random entries
module fat_directory_entry_scan_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fdes_pkg::*;

    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 8;
    localparam int TIMEOUT_CYCLES = 300000;

    localparam logic [7:0] ATTR_NONE   = 8'h00;
    localparam logic [7:0] ATTR_VOLUME = 8'(1 << ATTR_VOLUME_BIT);
    localparam logic [7:0] ATTR_DIR    = 8'(1 << ATTR_DIR_BIT);

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  push      = 1'b0;
    logic                  full;
    entry_t                entry     = '0;
    logic                  pop       = 1'b0;
    logic                  empty;
    result_t               result;

    entry_t  entries_to_send [$];
    result_t expected_chars [$];
    result_t next_char;

    // shadow of the registers and the scan state
    logic [15:0] target_reg = '0;
    logic [15:0] limit_reg  = '0;
    logic [15:0] slots_left = '0;
    logic [15:0] skips_left = '0;
    logic        scan_done  = 1'b1;

    int live_items    = 0;
    int errors        = 0;
    int send_idle_pct = 0;
    int pop_stall_pct = 0;
    int hold_req      = 0;
    int hold_done     = 0;
    int hold_left     = 0;
    int cycle_count   = 0;

    fat_directory_entry_scan u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .entry     (entry),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic report_missing();
        expected_chars.push_back(result_t'{1'b1, 8'h00, 1'b1});
        scan_done = 1'b1;
    endtask

    // advances the scan by one entry and queues the result items it yields (name or not-found)
    task automatic scan_entry(input entry_t e);
        logic [7:0] first;
        logic [7:0] c;
        logic [7:0] name_buf [12];
        int         n;
        first = e.base_name[7:0];
        n     = 0;
        live_items++;
        if (e.start_scan)
        begin
            slots_left = limit_reg;
            skips_left = target_reg;
            scan_done  = 1'b0;
            if (slots_left == 16'd0)
            begin
                report_missing();
                return;
            end
        end
        if (scan_done)
            return;
        if (first == MARK_END)
        begin
            report_missing();
            return;
        end
        if (e.attributes[ATTR_VOLUME_BIT] || first == MARK_DELETED || skips_left != 16'd0)
        begin
            if (!e.attributes[ATTR_VOLUME_BIT] && first != MARK_DELETED)
                skips_left = skips_left - 16'd1;
            slots_left = slots_left - 16'd1;
            if (slots_left == 16'd0)
                report_missing();
            return;
        end
        for (int i = 0; i < 8; i++)
        begin
            c = e.base_name[8*i +: 8];
            if (c == CH_SPACE)
                break;
            name_buf[n] = c;
            n++;
        end
        // no dot only for a directory whose extension starts blank
        if (!(e.attributes[ATTR_DIR_BIT] && e.extension[7:0] == CH_SPACE))
        begin
            name_buf[n] = CH_DOT;
            n++;
        end
        for (int i = 0; i < 3; i++)
        begin
            c = e.extension[8*i +: 8];
            if (c == CH_SPACE)
                break;
            name_buf[n] = c;
            n++;
        end
        if (n == 0)
        begin
            name_buf[0] = 8'h00;
            n = 1;
        end
        for (int k = 0; k < n; k++)
            expected_chars.push_back(result_t'{1'b0, name_buf[k], k == n - 1});
        scan_done = 1'b1;
    endtask

    function automatic void check_field(string field, int want, int got);
        if (want != got)
        begin
            errors++;
            if (errors <= 30)
                $error("%s mismatch: expected %0h, actual %0h", field, want, got);
        end
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
            push <= 1'b0;
        else
        begin
            if (push && !full)
            begin
                scan_entry(entry);
                void'(entries_to_send.pop_front());
            end
            if (!(push && full))
            begin
                if (entries_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    push  <= 1'b1;
                    entry <= entries_to_send[0];
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (expected_chars.size() == 0)
                begin
                    errors++;
                    $error("unexpected result: status %0h character %0h last %0h",
                           result.status, result.character, result.last);
                end
                else
                begin
                    next_char = expected_chars.pop_front();
                    check_field("status", next_char.status, result.status);
                    check_field("character", next_char.character, result.character);
                    check_field("last", next_char.last, result.last);
                end
            end
            pop <= (hold_left == 0) && ($urandom_range(99) >= pop_stall_pct);
        end
    end

    // long receiver hold-off
    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_done != hold_req)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= hold_req;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == TIMEOUT_CYCLES)
        begin
            $display("[fat_directory_entry_scan] ERROR");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx == REG_TARGET_INDEX)
            target_reg = value;
        else
            limit_reg = value;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (entries_to_send.size() != 0 || push || expected_chars.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic logic [63:0] pack_text(string s, int n);
        logic [63:0] v;
        v = '0;
        for (int i = 0; i < n; i++)
            v[8*i +: 8] = (i < s.len()) ? s[i] : CH_SPACE;
        return v;
    endfunction

    function automatic entry_t mk(logic s, string base, string ext, logic [7:0] attr);
        entry_t      e;
        logic [63:0] x;
        e.start_scan = s;
        e.base_name  = pack_text(base, 8);
        x            = pack_text(ext, 3);
        e.extension  = x[23:0];
        e.attributes = attr;
        return e;
    endfunction

    function automatic logic [7:0] rand_char();
        if ($urandom_range(4) == 0)
            return 8'($urandom_range(255));
        return 8'($urandom_range(8'h7E, 8'h21));
    endfunction

    // name field with a random length; bytes after the first blank are mostly blank
    function automatic logic [63:0] rand_field(int nbytes);
        logic [63:0] b;
        int          len;
        b   = '0;
        len = $urandom_range(nbytes);
        for (int i = 0; i < nbytes; i++)
        begin
            if (i < len)
                b[8*i +: 8] = rand_char();
            else if (i == len || $urandom_range(3) != 0)
                b[8*i +: 8] = CH_SPACE;
            else
                b[8*i +: 8] = rand_char();
        end
        if (b[7:0] == MARK_END || b[7:0] == MARK_DELETED)
            b[7:0] = 8'h41;
        return b;
    endfunction

    function automatic entry_t valid_entry(logic s);
        entry_t      e;
        logic [63:0] x;
        e.start_scan = s;
        e.base_name  = rand_field(8);
        x            = rand_field(3);
        e.extension  = x[23:0];
        e.attributes = 8'($urandom_range(255));
        e.attributes[ATTR_VOLUME_BIT] = 1'b0;
        return e;
    endfunction

    // one scan: a start then a few entries, or now and then pure noise
    task automatic add_scan();
        entry_t e;
        int     len;
        int     kind;
        if ($urandom_range(9) == 0)
        begin
            repeat ($urandom_range(4, 1))
            begin
                e = entry_t'({1'($urandom_range(1)), $urandom, $urandom, 24'($urandom),
                              8'($urandom)});
                entries_to_send.push_back(e);
            end
            return;
        end
        entries_to_send.push_back(valid_entry(1'b1));
        len = $urandom_range(6);
        repeat (len)
        begin
            kind = $urandom_range(99);
            e    = valid_entry(1'b0);
            if (kind < 10)
                e.base_name[7:0] = MARK_DELETED;
            else if (kind < 20)
                e.attributes[ATTR_VOLUME_BIT] = 1'b1;
            else if (kind < 24)
                e.base_name[7:0] = MARK_END;
            else if (kind < 30)
                e.start_scan = 1'b1;
            entries_to_send.push_back(e);
        end
    endtask

    task automatic run_phase(input logic [15:0] target, input logic [15:0] limit,
                             input int send_pct, input int stall_pct, input int goal,
                             input bit pressure);
        int goal_mark;
        wait_idle();
        write_reg(REG_TARGET_INDEX, target);
        write_reg(REG_ENTRIES_LIMIT, limit);
        @(negedge clk);
        send_idle_pct = send_pct;
        pop_stall_pct = stall_pct;
        goal_mark     = live_items + goal;
        if (pressure)
            hold_req++;
        while (live_items < goal_mark)
        begin
            if (entries_to_send.size() < 4)
                add_scan();
            @(negedge clk);
        end
    endtask

    initial
    begin
        entry_t d;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // skipping, volume label, deleted entry, limit used up, restart
        write_reg(REG_TARGET_INDEX, 16'd1);
        write_reg(REG_ENTRIES_LIMIT, 16'd3);
        @(negedge clk);
        entries_to_send.push_back(mk(1'b0, "IGNORED", "TXT", ATTR_NONE));
        entries_to_send.push_back(mk(1'b1, "FIRST", "BIN", ATTR_NONE));
        entries_to_send.push_back(mk(1'b0, "VOLUME", "LBL", ATTR_VOLUME));
        d = mk(1'b0, "XDELETED", "TMP", ATTR_NONE);
        d.base_name[7:0] = MARK_DELETED;
        entries_to_send.push_back(d);
        entries_to_send.push_back(mk(1'b1, "SKIPME", "", ATTR_NONE));
        entries_to_send.push_back(mk(1'b0, "README", "TXT", ATTR_NONE));
        entries_to_send.push_back(mk(1'b1, "AB", "C", ATTR_NONE));
        entries_to_send.push_back(mk(1'b1, "ABCDEFGH", "XYZ", ATTR_NONE));
        entries_to_send.push_back(entry_t'{1'b0, {{7{8'hFF}}, MARK_END}, 24'hFFFFFF, 8'hFF});
        wait_idle();

        // zero limit
        write_reg(REG_TARGET_INDEX, 16'd0);
        write_reg(REG_ENTRIES_LIMIT, 16'd0);
        @(negedge clk);
        entries_to_send.push_back(mk(1'b1, "ZERO", "LIM", ATTR_NONE));
        entries_to_send.push_back(mk(1'b0, "AFTER", "", ATTR_NONE));
        wait_idle();

        // name formatting corners
        write_reg(REG_ENTRIES_LIMIT, 16'hFFFF);
        @(negedge clk);
        entries_to_send.push_back(mk(1'b1, "", "", ATTR_DIR));
        entries_to_send.push_back(mk(1'b1, "SUBDIR", "", ATTR_DIR));
        entries_to_send.push_back(mk(1'b1, "NOEXT", "", ATTR_NONE));
        entries_to_send.push_back(mk(1'b1, "", "", ATTR_NONE));
        entries_to_send.push_back(mk(1'b1, "ABCDEFGH", "XYZ", ATTR_DIR));
        entries_to_send.push_back(entry_t'{1'b1, {8{8'hFF}}, 24'hFFFFFF, 8'hF7});
        entries_to_send.push_back(mk(1'b1, "A B", "C D", ATTR_NONE));
        entries_to_send.push_back(entry_t'{1'b1, {8{MARK_END}}, 24'h000000, ATTR_NONE});
        wait_idle();

        // widest target, scan closed by an end marker
        write_reg(REG_TARGET_INDEX, 16'hFFFF);
        @(negedge clk);
        entries_to_send.push_back(mk(1'b1, "ONE", "", ATTR_NONE));
        entries_to_send.push_back(mk(1'b0, "TWO", "", ATTR_NONE));
        entries_to_send.push_back(entry_t'{1'b0, {{7{8'h41}}, MARK_END}, 24'h414141, ATTR_DIR});
        wait_idle();

        // single slot
        write_reg(REG_TARGET_INDEX, 16'd0);
        write_reg(REG_ENTRIES_LIMIT, 16'd1);
        @(negedge clk);
        entries_to_send.push_back(mk(1'b1, "VOL", "", ATTR_VOLUME));
        d = mk(1'b1, "XGONE", "", ATTR_NONE);
        d.base_name[7:0] = MARK_DELETED;
        entries_to_send.push_back(d);
        entries_to_send.push_back(mk(1'b1, "LAST", "", ATTR_NONE));

        run_phase(16'd2, 16'd6, 0, 0, 50, 1'b0);
        run_phase(16'd0, 16'd1, 68, 0, 40, 1'b0);
        run_phase(16'hFFFF, 16'd5, 0, 68, 40, 1'b0);
        run_phase(16'd1, 16'hFFFF, 32, 32, 50, 1'b0);
        run_phase(16'd0, 16'd0, 0, 0, 25, 1'b0);
        run_phase(16'd0, 16'd4, 0, 0, 50, 1'b1);
        repeat (3)
            run_phase(16'($urandom_range(3)), 16'($urandom_range(8, 1)), 32, 32, 15, 1'b0);
        wait_idle();

        if (errors == 0)
            $display("[fat_directory_entry_scan] OK");
        else
            $display("[fat_directory_entry_scan] ERROR");
        $finish;
    end

endmodule
